[src/ttc_emergency_brake_detector_core_macros.svh]
// Assertion macros shared by the brake detector RTL.
`ifndef TTC_EMERGENCY_BRAKE_DETECTOR_CORE_MACROS_SVH
`define TTC_EMERGENCY_BRAKE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TTC_EBD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define TTC_EBD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/ttc_ebd_pkg.sv]
// Shared types, constants and tables of the brake detector.
`default_nettype none
package ttc_ebd_pkg;

    localparam int MAX_BEAMS   = 4096;
    localparam int CORDIC_ITERS = 14;
    localparam logic [16:0] TTC_CAP = 17'd100000;
    // 1/K of the CORDIC gain, Q15
    localparam logic signed [15:0] INV_K = 16'sd19899;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ANGLE_START   = 3'd0,
        CFG_ANGLE_STEP    = 3'd1,
        CFG_RANGE_FLOOR   = 3'd2,
        CFG_RANGE_CEILING = 3'd3,
        CFG_TTC_LIMIT     = 3'd4
    } cfg_index_t;

    // status from the TTC unit to the sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } unit_stat_t;

    // CORDIC arctangent table, binary angle units
    function automatic logic signed [17:0] atan_lut(input logic [3:0] i);
        logic signed [17:0] v;
        case (i)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[src/ttc_ebd_unit.sv]
// Shared CORDIC rotator, scaler and restoring divider for one beam's TTC.
`default_nettype none
module ttc_ebd_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [15:0]       vel_x,
    input  wire logic signed [15:0]       vel_y,
    input  wire logic signed [15:0]       angle,
    input  wire logic [15:0]              range_mm,
    output ttc_ebd_pkg::unit_stat_t       stat,
    output logic [16:0]                   ttc
);

    typedef enum logic [2:0] {U_IDLE, U_ROT, U_MUL, U_CHK, U_DIV, U_DONE} ustate_t;

    ustate_t               state_reg;
    logic [3:0]            iter_reg;
    logic [4:0]            bit_reg;
    logic signed [27:0]    x_reg, y_reg;
    logic signed [17:0]    z_reg;
    logic signed [43:0]    rate_reg;
    logic [48:0]           rem_reg;
    logic [16:0]           q_reg;
    logic [16:0]           ttc_reg;
    logic                  hit_reg;

    // fold angle into +-quarter turn
    logic                  fold;
    logic signed [16:0]    vx17, vy17, a17;
    logic signed [17:0]    z_init;
    always_comb
    begin
        fold = (angle > 16'sd16384) || (angle < -16'sd16384);
        vx17 = fold ? -17'(vel_x) : 17'(vel_x);
        vy17 = fold ? -17'(vel_y) : 17'(vel_y);
        if (!fold)
            a17 = 17'(angle);
        else if (angle < 16'sd0)
            a17 = 17'(angle) + 17'sd32768;
        else
            a17 = 17'(angle) - 17'sd32768;
        z_init = -18'(a17);
    end

    // one CORDIC micro-rotation
    logic signed [27:0] xs, ys;
    always_comb
    begin
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
    end

    // numerator, divisor and trial subtraction
    logic [25:0]  range_k;
    logic [48:0]  num;
    logic [42:0]  rate_mag;
    logic [59:0]  d_top, d_bit;
    logic [59:0]  rem_ext;
    always_comb
    begin
        range_k  = 26'(range_mm) * 26'd1000;
        num      = {range_k, 23'd0};
        rate_mag = rate_reg[42:0];
        d_top    = 60'(rate_mag) << 17;
        d_bit    = 60'(rate_mag) << bit_reg;
        rem_ext  = 60'(rem_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            iter_reg  <= '0;
            bit_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= 28'(vx17) <<< 8;
                        y_reg     <= 28'(vy17) <<< 8;
                        z_reg     <= z_init;
                        iter_reg  <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= U_ROT;
                    end
                end
                U_ROT:
                begin
                    if (z_reg >= 18'sd0)
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - ttc_ebd_pkg::atan_lut(iter_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + ttc_ebd_pkg::atan_lut(iter_reg);
                    end
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'(ttc_ebd_pkg::CORDIC_ITERS - 1))
                        state_reg <= U_MUL;
                end
                U_MUL:
                begin
                    rate_reg  <= 44'(x_reg) * 44'(ttc_ebd_pkg::INV_K);
                    state_reg <= U_CHK;
                end
                U_CHK:
                begin
                    rem_reg <= num;
                    q_reg   <= '0;
                    bit_reg <= 5'd16;
                    if (rate_reg <= 44'sd0)
                    begin
                        state_reg <= U_DONE;
                    end
                    else if (60'(num) >= d_top)
                    begin
                        // quotient beyond the cap
                        ttc_reg   <= ttc_ebd_pkg::TTC_CAP;
                        hit_reg   <= 1'b1;
                        state_reg <= U_DONE;
                    end
                    else
                    begin
                        state_reg <= U_DIV;
                    end
                end
                U_DIV:
                begin
                    if (rem_ext >= d_bit)
                    begin
                        rem_reg        <= 49'(rem_ext - d_bit);
                        q_reg[bit_reg] <= 1'b1;
                    end
                    if (bit_reg == 5'd0)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= U_DONE;
                    end
                    bit_reg <= bit_reg - 5'd1;
                end
                U_DONE:
                begin
                    if (q_reg > ttc_ebd_pkg::TTC_CAP && ttc_reg != ttc_ebd_pkg::TTC_CAP)
                        ttc_reg <= ttc_ebd_pkg::TTC_CAP;
                    state_reg <= U_IDLE;
                end
                default: state_reg <= U_IDLE;
            endcase
            // divider result lands when the last bit is resolved
            if (state_reg == U_DIV && bit_reg == 5'd0)
                ttc_reg <= (rem_ext >= d_bit) ? (q_reg | 17'd1) : q_reg;
        end
    end

    // clamp on the way out
    always_comb
    begin
        stat.done = (state_reg == U_DONE);
        stat.hit  = hit_reg;
        ttc       = (ttc_reg > ttc_ebd_pkg::TTC_CAP) ? ttc_ebd_pkg::TTC_CAP : ttc_reg;
    end

endmodule
`default_nettype wire

[src/ttc_emergency_brake_detector_core.sv]
// Each accepted beam passes the sequencer start state, the CORDIC rotation, multiply,
// check, divide and done states, then the output register; a capped or non-closing beam
// skips the divide, an out-of-window beam skips the unit. A new item is taken only in idle,
// after the last beam's result is registered; a velocity item gives no result; a stalled output holds.
// Reset (rst_n low, async): registers to defaults, velocity 0, counter 0,
// scan minimum 100000 ms, output empty.
`default_nettype none
`include "ttc_emergency_brake_detector_core_macros.svh"
module ttc_emergency_brake_detector_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // vel_x[15:0], vel_y[31:16], range_mm[47:32]
    input  wire logic        s_axis_tuser,  // operation
    input  wire logic        s_axis_tlast,  // last_beam
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // brake[0], min_ttc_ms[17:1], beam_number[29:18], 0
    output logic             m_axis_tlast   // scan_end
);

    typedef enum logic [1:0] {S_IDLE, S_START, S_RUN, S_RES} state_t;

    state_t              state_reg;
    logic [15:0]         angle_start_reg;
    logic [11:0]         angle_step_reg;
    logic [15:0]         range_floor_reg, range_ceiling_reg;
    logic [16:0]         ttc_limit_reg;
    logic signed [15:0]  vel_x_reg, vel_y_reg;
    logic [11:0]         beam_cnt_reg;
    logic [16:0]         min_reg;
    logic signed [15:0]  angle_reg;
    logic [15:0]         range_reg;
    logic                valid_reg, last_reg, hit_reg;
    logic [16:0]         ttc_reg;
    logic                out_valid_reg, out_brake_reg, out_last_reg;
    logic [16:0]         out_min_reg;
    logic [11:0]         out_beam_reg;

    ttc_ebd_pkg::unit_stat_t ustat;
    logic [16:0]             uttc;
    logic                    ustart;

    // beam angle and range window for an arriving item
    logic [23:0]  step_prod;
    logic [15:0]  angle_next;
    logic [15:0]  in_range;
    logic         in_valid;
    always_comb
    begin
        step_prod  = 24'(beam_cnt_reg) * 24'(angle_step_reg);
        angle_next = angle_start_reg + step_prod[15:0];
        in_range   = s_axis_tdata[47:32];
        in_valid   = (in_range >= range_floor_reg) && (in_range <= range_ceiling_reg);
    end

    // minimum update and counter wrap
    logic [16:0] min_next;
    logic [12:0] cnt_inc;
    always_comb
    begin
        min_next = (hit_reg && ttc_reg < min_reg) ? ttc_reg : min_reg;
        cnt_inc  = 13'(beam_cnt_reg) + 13'd1;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign ustart        = (state_reg == S_START) && valid_reg;

    ttc_ebd_unit u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ustart),
        .vel_x    (vel_x_reg),
        .vel_y    (vel_y_reg),
        .angle    (angle_reg),
        .range_mm (range_reg),
        .stat     (ustat),
        .ttc      (uttc)
    );

    // sequencer, state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            angle_start_reg   <= 16'hA000;
            angle_step_reg    <= 12'd46;
            range_floor_reg   <= 16'd0;
            range_ceiling_reg <= 16'd30000;
            ttc_limit_reg     <= 17'd400;
            vel_x_reg         <= '0;
            vel_y_reg         <= '0;
            beam_cnt_reg      <= '0;
            min_reg           <= ttc_ebd_pkg::TTC_CAP;
            out_valid_reg     <= 1'b0;
            hit_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ttc_ebd_pkg::CFG_ANGLE_START:   angle_start_reg   <= cfg_data[15:0];
                    ttc_ebd_pkg::CFG_ANGLE_STEP:    angle_step_reg    <= cfg_data[11:0];
                    ttc_ebd_pkg::CFG_RANGE_FLOOR:   range_floor_reg   <= cfg_data[15:0];
                    ttc_ebd_pkg::CFG_RANGE_CEILING: range_ceiling_reg <= cfg_data[15:0];
                    ttc_ebd_pkg::CFG_TTC_LIMIT:     ttc_limit_reg     <= cfg_data;
                    default: ;
                endcase
            end
            // drain the output slot unless a new result reloads it
            if (out_valid_reg && m_axis_tready && state_reg != S_RES)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (!s_axis_tuser)
                        begin
                            vel_x_reg <= s_axis_tdata[15:0];
                            vel_y_reg <= s_axis_tdata[31:16];
                        end
                        else
                        begin
                            angle_reg <= angle_next;
                            range_reg <= in_range;
                            valid_reg <= in_valid;
                            last_reg  <= s_axis_tlast;
                            hit_reg   <= 1'b0;
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    state_reg <= valid_reg ? S_RUN : S_RES;
                end
                S_RUN:
                begin
                    if (ustat.done)
                    begin
                        hit_reg   <= ustat.hit;
                        ttc_reg   <= uttc;
                        state_reg <= S_RES;
                    end
                end
                S_RES:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_brake_reg <= valid_reg && (min_next <= ttc_limit_reg);
                        out_min_reg   <= min_next;
                        out_beam_reg  <= beam_cnt_reg;
                        out_last_reg  <= last_reg;
                        if (last_reg)
                        begin
                            beam_cnt_reg <= '0;
                            min_reg      <= ttc_ebd_pkg::TTC_CAP;
                        end
                        else
                        begin
                            beam_cnt_reg <= (cnt_inc >= 13'(ttc_ebd_pkg::MAX_BEAMS))
                                            ? 12'd0 : cnt_inc[11:0];
                            min_reg      <= min_next;
                        end
                        state_reg <= S_IDLE;
                    end
                    else if (out_valid_reg && m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_beam_reg, out_min_reg, out_brake_reg};
    assign m_axis_tlast  = out_last_reg;

    // a beam always leaves the idle state
    `TTC_EBD_ASSERT_NXT(a_beam_busy, clk, rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser, state_reg != S_IDLE)
    // reported minimum never exceeds the cap
    `TTC_EBD_ASSERT_IMP(a_min_cap, clk, rst_n,
        out_valid_reg, out_min_reg <= ttc_ebd_pkg::TTC_CAP)
    // brake only with a minimum at or below the limit
    `TTC_EBD_ASSERT_IMP(a_brake_lim, clk, rst_n,
        out_valid_reg && out_brake_reg, out_min_reg <= ttc_limit_reg)
    // unit only finishes while the sequencer waits for it
    `TTC_EBD_ASSERT_IMP(a_unit_done, clk, rst_n, ustat.done, state_reg == S_RUN)

endmodule
`default_nettype wire
